[rtl/alid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_pkg - shared types and constants of the array list unit
// Field widths, word packing positions, action codes and the command that
// the control logic broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package alid_pkg;

  // Field widths
  localparam int unsigned ACT_W = 2;
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 5;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Largest count the 5-bit count and limit can express
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

  // Limit register value after reset
  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  // Broadcast to the cell row for one accepted, carried-out action
  typedef struct packed {
    logic             en;
    action_e          act;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

[rtl/array_list_insert_delete_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_unit - ordered list of signed words
// Append, insert, delete and read on a list kept in a row of shift cells.
// ----------------------------------------------------------------------------
// The unit takes one input word per clock and answers each with exactly one
// registered result word in the next cycle; it stalls only while a result
// waits on the output. The list lives in a row of CAPACITY cells: on insert
// every cell above the position takes its lower neighbor's word, on delete
// every cell from the position up takes its upper neighbor's word, all in
// the same cycle, so the shift across the cell row adds no stall. The
// usable size is the smaller of the limit register, CAPACITY and 31. Write
// the limit only while no result is outstanding; lowering it below the count
// keeps the held elements. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module array_list_insert_delete_unit
  import alid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Limit register write
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] action, [6:2] position, [38:7] value, [39] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] accepted, [32:1] read_value, [37:33] count, [38] full_res,
  // [39] empty_res
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CapClip = (CAPACITY > CNT_MAX) ? CNT_MAX : CAPACITY;
  localparam logic [CNT_W-1:0] CapLim = CNT_W'(CapClip);

  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lim;
  logic             fire, ok, can_grow;
  action_e          act;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [VAL_W-1:0] rd_val;
  cell_cmd_t        cmd;
  logic [VAL_W-1:0] words [CAPACITY];

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Unpack the request word
  assign act = action_e'(s_axis_tdata[ACT_W-1:0]);
  assign pos = s_axis_tdata[ACT_W +: POS_W];
  assign val = s_axis_tdata[ACT_W+POS_W +: VAL_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign lim      = (limit_q < CapLim) ? limit_q : CapLim;
  assign can_grow = cnt_q < lim;

  // Decide whether the action is carried out and the new count
  always_comb begin
    ok    = 1'b0;
    cnt_d = cnt_q;
    case (act)
      ACT_APPEND: begin
        ok = can_grow;
        if (ok) cnt_d = cnt_q + CNT_W'(1);
      end
      ACT_INSERT: begin
        ok = can_grow && (pos <= cnt_q);
        if (ok) cnt_d = cnt_q + CNT_W'(1);
      end
      ACT_DELETE: begin
        ok = pos < cnt_q;
        if (ok) cnt_d = cnt_q - CNT_W'(1);
      end
      default: begin
        ok = pos < cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire) begin
      cnt_q <= cnt_d;
    end
  end

  // Broadcast the command to the cell row
  assign cmd.en    = fire && ok;
  assign cmd.act   = act;
  assign cmd.pos   = pos;
  assign cmd.cnt   = cnt_q;
  assign cmd.value = val;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_lo
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_hi
      assign right_w = words[i+1];
    end
    alid_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_w),
      .right_i(right_w),
      .word_o (words[i])
    );
  end

  // Select the word at the read position
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(pos) == i) rd_val = words[i];
    end
    if (!(ok && act == ACT_READ)) rd_val = '0;
  end

  // Pack the result word
  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = ok;
    out_data_d[32:1]  = rd_val;
    out_data_d[37:33] = cnt_d;
    out_data_d[38]    = cnt_d >= lim;
    out_data_d[39]    = cnt_d == '0;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/alid_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_cell - one storage place of the list
// Holds one word and, on a broadcast command, keeps it, loads the new
// value, or takes the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module alid_cell
  import alid_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [VAL_W-1:0] left_i,   // word of the cell below (index - 1)
  input  logic [VAL_W-1:0] right_i,  // word of the cell above (index + 1)
  output logic [VAL_W-1:0] word_o
);

  logic [VAL_W-1:0] word_q, word_d;

  // Pick the next word from the command and this cell's place
  always_comb begin
    word_d = word_q;
    if (cmd_i.en) begin
      case (cmd_i.act)
        ACT_APPEND: begin
          if (IDX == 32'(cmd_i.cnt)) word_d = cmd_i.value;
        end
        ACT_INSERT: begin
          if (IDX == 32'(cmd_i.pos)) begin
            word_d = cmd_i.value;
          end else if (IDX > 32'(cmd_i.pos)) begin
            word_d = left_i;
          end
        end
        ACT_DELETE: begin
          if (IDX >= 32'(cmd_i.pos)) word_d = right_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[rtl/alid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_checker - port-level checks of the array list unit
// Watches the result stream and the request ready over time.
// ----------------------------------------------------------------------------
module alid_checker
  import alid_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Accept a request whenever no result waits
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request not taken while output empty");

  // Empty flag follows the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39] == (m_axis_tdata[37:33] == '0)))
    else $error("empty flag disagrees with count");

  // Refused actions return no read data
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == '0)
    else $error("read data on a refused action");

  // An empty result may show full only with a zero count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39] |-> !m_axis_tdata[38] || m_axis_tdata[37:33] == '0)
    else $error("full and empty with nonzero count");

endmodule

bind array_list_insert_delete_unit alid_checker u_alid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the array list unit
// Streams append, insert, delete and read words into the unit and checks
// every result word against a cycle-free model of the list kept in the
// bench. The run walks through several limit settings and idle patterns on
// both stream sides.
// ----------------------------------------------------------------------------
module tb_top
  import alid_pkg::*;
();

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDLE_NONE  = 0;
  localparam int unsigned IDLE_HEAVY = 69;
  localparam int unsigned IDLE_BOTH  = 34;
  localparam int unsigned SHOW_MAX   = 10;

  // Request word: [1:0] action, [6:2] position, [38:7] value, [39] zero
  typedef struct packed {
    logic             pad;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    action_e          act;
  } list_req_t;

  // Result word: [0] accepted, [32:1] read_value, [37:33] count,
  // [38] full_res, [39] empty_res
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] read_value;
    logic             accepted;
  } list_reply_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Model of the list as the unit should hold it
  logic [VAL_W-1:0] list_words [DEPTH];
  int unsigned      list_len = 0;
  int unsigned      list_cap = 16;

  // Count tracker used to aim the generated positions and size the directed runs
  int unsigned gen_len = 0;
  int unsigned gen_cap = 16;

  list_req_t   pending_ops[$];
  list_reply_t awaited_replies[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned send_idle_pct = IDLE_NONE;
  int unsigned recv_stall_pct = IDLE_NONE;

  array_list_insert_delete_unit #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one action to the list model and return the reply it should give
  function automatic list_reply_t apply_list_op(list_req_t req);
    list_reply_t res;
    int unsigned lim;
    int unsigned i;
    lim = (list_cap < DEPTH) ? list_cap : DEPTH;
    res = '0;
    case (req.act)
      ACT_APPEND: begin
        if (list_len < lim) begin
          list_words[list_len] = req.value;
          list_len++;
          res.accepted = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (list_len < lim && req.pos <= list_len) begin
          for (i = list_len; i > req.pos; i--) list_words[i] = list_words[i-1];
          list_words[req.pos] = req.value;
          list_len++;
          res.accepted = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (req.pos < list_len) begin
          for (i = req.pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          res.accepted = 1'b1;
        end
      end
      default: begin
        if (req.pos < list_len) begin
          res.read_value = list_words[req.pos];
          res.accepted   = 1'b1;
        end
      end
    endcase
    res.count = CNT_W'(list_len);
    res.full  = (list_len >= lim);
    res.empty = (list_len == 0);
    return res;
  endfunction

  // Queue one request and track the count it leads to
  task automatic push_op(action_e act, int unsigned pos, logic [VAL_W-1:0] value);
    list_req_t req;
    req.pad   = 1'b0;
    req.act   = act;
    req.pos   = POS_W'(pos);
    req.value = value;
    pending_ops.push_back(req);
    case (act)
      ACT_APPEND: if (gen_len < gen_cap) gen_len++;
      ACT_INSERT: if (gen_len < gen_cap && req.pos <= gen_len) gen_len++;
      ACT_DELETE: if (req.pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // Queue random requests: mostly valid positions, with growing and
  // shrinking stretches so the list swings between empty and full
  task automatic push_random_ops(int unsigned n);
    int unsigned k;
    int unsigned r;
    int unsigned pos;
    bit          grow;
    action_e     act;
    logic [VAL_W-1:0] value;
    grow = 1'b1;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) grow = $urandom_range(1);
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: value = '0;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'h8000_0000;
          default: value = 32'hFFFF_FFFF;
        endcase
      end else begin
        value = $urandom();
      end
      if (r < 8) begin
        // noise: any action at any position
        act = action_e'($urandom_range(3));
        pos = $urandom_range(31);
      end else begin
        r = $urandom_range(99);
        if (grow) begin
          act = (r < 30) ? ACT_APPEND : (r < 65) ? ACT_INSERT :
                (r < 80) ? ACT_DELETE : ACT_READ;
        end else begin
          act = (r < 10) ? ACT_APPEND : (r < 25) ? ACT_INSERT :
                (r < 70) ? ACT_DELETE : ACT_READ;
        end
        case (act)
          ACT_APPEND: pos = $urandom_range(31);
          ACT_INSERT: pos = $urandom_range(gen_len);
          default:    pos = (gen_len != 0) ? $urandom_range(gen_len - 1) : 0;
        endcase
      end
      push_op(act, pos, value);
    end
  endtask

  // Hold until every queued word is taken and every reply has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    list_cap = limit;
    gen_cap  = (limit < DEPTH) ? limit : DEPTH;
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Drive the request side: advance to the next word once the current one
  // is taken, or idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_ops.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result word against the oldest reply, then predict the reply
  // for a request word taken at this edge
  always @(posedge clk_i) begin : scoreboard
    list_reply_t got;
    list_reply_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = list_reply_t'(m_axis_tdata);
        if (awaited_replies.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX)
            $display("%0t: result word with no reply awaited: %h", $realtime, m_axis_tdata);
        end else begin
          want = awaited_replies.pop_front();
          if (got.accepted !== want.accepted || got.read_value !== want.read_value ||
              got.count !== want.count || got.full !== want.full ||
              got.empty !== want.empty) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_MAX) begin
              $display("%0t: mismatch: expected ok=%0b rd=%h cnt=%0d full=%0b empty=%0b",
                       $realtime, want.accepted, want.read_value, want.count, want.full,
                       want.empty);
              $display("%0t: mismatch: got ok=%0b rd=%h cnt=%0d full=%0b empty=%0b",
                       $realtime, got.accepted, got.read_value, got.count, got.full,
                       got.empty);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_replies.push_back(apply_list_op(list_req_t'(s_axis_tdata)));
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty list, extreme values, edge positions, refusals
    set_idle(IDLE_NONE, IDLE_NONE);
    push_op(ACT_READ,   0,  32'h0);
    push_op(ACT_DELETE, 0,  32'h0);
    push_op(ACT_APPEND, 31, 32'h7FFF_FFFF);
    push_op(ACT_APPEND, 0,  32'h8000_0000);
    push_op(ACT_INSERT, 0,  32'hFFFF_FFFF);
    push_op(ACT_INSERT, 3,  32'h0);
    push_op(ACT_INSERT, 31, 32'h1234_5678);
    push_op(ACT_INSERT, 5,  32'h5555_AAAA);
    push_op(ACT_READ,   0,  32'h0);
    push_op(ACT_READ,   3,  32'h0);
    push_op(ACT_READ,   4,  32'h0);
    push_op(ACT_READ,   31, 32'hFFFF_FFFF);
    push_op(ACT_DELETE, 1,  32'h0);
    push_op(ACT_DELETE, 3,  32'h0);
    push_op(ACT_DELETE, 31, 32'h0);
    push_op(ACT_DELETE, 2,  32'h0);
    push_op(ACT_READ,   1,  32'h0);
    push_random_ops(240);
    wait_drained();

    // Limit above the store depth, sender idling; end well filled
    write_limit(CNT_W'(31));
    set_idle(IDLE_HEAVY, IDLE_NONE);
    push_random_ops(230);
    while (gen_len < 12) push_op(ACT_APPEND, 0, $urandom());
    wait_drained();

    // Limit lowered below the count: held elements stay
    write_limit(CNT_W'(3));
    set_idle(IDLE_NONE, IDLE_HEAVY);
    push_op(ACT_APPEND, 0, 32'h1);
    push_op(ACT_INSERT, 0, 32'h2);
    push_random_ops(60);
    wait_drained();

    // Limit zero: drain the list, then everything is refused
    write_limit(CNT_W'(0));
    set_idle(IDLE_NONE, IDLE_HEAVY);
    while (gen_len != 0) push_op(ACT_DELETE, 0, 32'h0);
    push_op(ACT_APPEND, 0, 32'hDEAD_BEEF);
    push_op(ACT_INSERT, 0, 32'hDEAD_BEEF);
    push_op(ACT_READ,   0, 32'h0);
    push_op(ACT_DELETE, 0, 32'h0);
    push_random_ops(40);
    wait_drained();

    // Single-entry list
    write_limit(CNT_W'(1));
    set_idle(IDLE_BOTH, IDLE_BOTH);
    push_random_ops(60);
    wait_drained();

    // Full depth again, both sides idling
    write_limit(CNT_W'(16));
    set_idle(IDLE_BOTH, IDLE_BOTH);
    push_random_ops(250);
    wait_drained();

    // Odd limit, no idling
    write_limit(CNT_W'(9));
    set_idle(IDLE_NONE, IDLE_NONE);
    push_random_ops(170);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && awaited_replies.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run
  initial begin
    #400_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[array_list_insert_delete_unit.f]
rtl/alid_pkg.sv
rtl/alid_cell.sv
rtl/array_list_insert_delete_unit.sv
rtl/alid_checker.sv
tb/tb_top.sv
